// File: hdl/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

    // Default sizes of the managed region and of the count field.
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_BITS_DEF  = 12;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed widths of the word fields and of the configuration port.
    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 32;
    localparam int REFCNT_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int FIRST_W    = 20;
    localparam int END_W      = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INIT  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BADADDR   = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;           // latch the accepted word and issue memory reads
        logic exec;           // carry out the latched operation
        logic sweep;          // one step of the page sweep
        logic push;           // the sweep also stacks pages of the region
        logic load_out;       // load the output register
        logic out_from_hold;  // output register takes the held result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_init;
        logic sweep_last;
    } sts_t;

endpackage

// File: hdl/rpa_op_if.sv
`timescale 1ns / 1ps

interface rpa_op_if;
    logic                          valid;
    logic                          ready;
    logic [rpa_pkg::KIND_W-1:0]    kind;
    logic [rpa_pkg::ADDR_W-1:0]    page_addr;

    modport source (output valid, kind, page_addr, input ready);
    modport sink   (input valid, kind, page_addr, output ready);
endinterface

// File: hdl/rpa_res_if.sv
`timescale 1ns / 1ps

interface rpa_res_if;
    logic                          valid;
    logic                          ready;
    logic [rpa_pkg::ADDR_W-1:0]    result_addr;
    logic [rpa_pkg::REFCNT_W-1:0]  ref_count;
    logic [rpa_pkg::STATUS_W-1:0]  status;

    modport source (output valid, result_addr, ref_count, status, input ready);
    modport sink   (input valid, result_addr, ref_count, status, output ready);
endinterface

// File: hdl/refcounted_page_allocator.sv
`timescale 1ns / 1ps

// Reference-counted page-frame allocator. Each word on the op channel is
// one operation (alloc, free, add reference, read count, init) and gives
// exactly one result word. Allocate, free, add and read first read the
// page's count and the top of the free stack from their single-port-read
// memories, then update them and form the result. Init walks every page
// once, clearing its count and stacking it if it lies in the region. After
// reset the block runs a clearing pass over the count memory and accepts
// no operation until it is done; configuration writes are taken at any
// time but should only be made while the block is idle. While a result
// word waits on the res channel, one further operation is accepted and
// carried out; its result is held inside, and no further operation is
// accepted until the waiting word has been taken.

module refcounted_page_allocator #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BITS  = rpa_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rpa_op_if.sink                         op,
    rpa_res_if.source                      res,
    input  logic                           cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data
);

    rpa_pkg::cmd_t cmd;
    rpa_pkg::sts_t sts;

    // Sequencer.
    rpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op.valid),
        .in_ready  (op.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Counts, free stack and result registers.
    rpa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_kind         (op.kind),
        .in_page_addr    (op.page_addr),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_result_addr (res.result_addr),
        .out_ref_count   (res.ref_count),
        .out_status      (res.status)
    );

endmodule

// File: hdl/rpa_ram.sv
`timescale 1ns / 1ps

module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rpa_ctrl.sv
`timescale 1ns / 1ps

module rpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output rpa_pkg::cmd_t cmd,
    input  rpa_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The output register can take a result when empty or being emptied.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.is_init)
                begin
                    state_next = S_SWEEP;
                end
                else if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                cmd.push  = 1'b1;
                if (sts.sweep_last)
                begin
                    if (slot_free)
                    begin
                        cmd.load_out      = 1'b1;
                        cmd.out_from_hold = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out      = 1'b1;
                    cmd.out_from_hold = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and handshakes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/rpa_datapath.sv
`timescale 1ns / 1ps

module rpa_datapath #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BITS  = rpa_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rpa_pkg::cmd_t                    cmd,
    output rpa_pkg::sts_t                    sts,
    input  logic [rpa_pkg::KIND_W-1:0]       in_kind,
    input  logic [rpa_pkg::ADDR_W-1:0]       in_page_addr,
    input  logic                             cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [rpa_pkg::ADDR_W-1:0]       out_result_addr,
    output logic [rpa_pkg::REFCNT_W-1:0]     out_ref_count,
    output logic [rpa_pkg::STATUS_W-1:0]     out_status
);

    localparam int PG_W  = $clog2(NUM_PAGES);
    localparam int DEP_W = $clog2(NUM_PAGES + 1);
    localparam int AW    = rpa_pkg::ADDR_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [DEP_W-1:0]      DEP_FULL = DEP_W'(NUM_PAGES);
    localparam logic [PG_W-1:0]       IDX_LAST = PG_W'(NUM_PAGES - 1);
    localparam logic [AW-1:0]         NUM_PAGES_W = AW'(NUM_PAGES);

    // Configuration registers.
    logic [rpa_pkg::FIRST_W-1:0] first_page_reg;
    logic [rpa_pkg::END_W-1:0]   end_page_reg;

    // Latched operation.
    logic [rpa_pkg::KIND_W-1:0] kind_reg;
    logic [PG_W-1:0]            page_reg;
    logic                       valid_reg;
    logic                       aligned_reg;

    // Stack pointer and sweep index.
    logic [DEP_W-1:0] depth_reg;
    logic [DEP_W-1:0] depth_next;
    logic [PG_W-1:0]  idx_reg;
    logic [PG_W-1:0]  idx_next;

    // Held and output result.
    logic [AW-1:0]                hold_addr_reg;
    logic [rpa_pkg::REFCNT_W-1:0] hold_cnt_reg;
    rpa_pkg::status_t             hold_st_reg;
    logic [AW-1:0]                out_addr_reg;
    logic [rpa_pkg::REFCNT_W-1:0] out_cnt_reg;
    rpa_pkg::status_t             out_st_reg;

    // Region bounds and address decode.
    logic [AW-1:0]    first_w;
    logic [AW-1:0]    end_w;
    logic [AW-1:0]    end_eff;
    logic [AW-1:0]    in_page;
    logic [AW-1:0]    idx_w;
    logic             in_page_ok;
    logic             idx_in_region;

    // Memory ports.
    logic                  cnt_we;
    logic [PG_W-1:0]       cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [PG_W-1:0]       stk_waddr;
    logic [PG_W-1:0]       stk_wdata;
    logic [PG_W-1:0]       stk_rdata;
    logic [DEP_W-1:0]      depth_dec;

    // Operation result.
    logic [AW-1:0]         r_addr;
    logic [COUNT_BITS-1:0] r_cnt;
    rpa_pkg::status_t      r_st;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [AW-1:0]         r_cnt_w;

    // Effective end of the region is clipped to the capacity.
    assign first_w = AW'(first_page_reg);
    assign end_w   = AW'(end_page_reg);
    assign end_eff = (end_w < NUM_PAGES_W) ? end_w : NUM_PAGES_W;

    assign in_page       = in_page_addr >> PAGE_BITS;
    assign in_page_ok    = (in_page >= first_w) && (in_page < end_eff);
    assign idx_w         = AW'(idx_reg);
    assign idx_in_region = (idx_w >= first_w) && (idx_w < end_eff);

    assign depth_dec = depth_reg - DEP_W'(1);
    assign cnt_dec   = cnt_rdata - CNT_ONE;
    assign cnt_inc   = cnt_rdata + CNT_ONE;

    assign sts.is_init    = (kind_reg == rpa_pkg::KIND_INIT);
    assign sts.sweep_last = (idx_reg == IDX_LAST);

    // Reference counts, one entry per page.
    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (cmd.take),
        .rd_addr (in_page[PG_W-1:0]),
        .rd_data (cnt_rdata)
    );

    // Free-page stack; only entries below the depth are ever used.
    rpa_ram #(
        .WIDTH (PG_W),
        .DEPTH (NUM_PAGES)
    ) u_stk_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (cmd.take),
        .rd_addr (depth_dec[PG_W-1:0]),
        .rd_data (stk_rdata)
    );

    // Operation execution, sweep steps and memory writes.
    always_comb
    begin
        r_addr     = '0;
        r_cnt      = '0;
        r_st       = rpa_pkg::ST_OK;
        cnt_we     = 1'b0;
        cnt_waddr  = page_reg;
        cnt_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[PG_W-1:0];
        stk_wdata  = page_reg;
        depth_next = depth_reg;
        idx_next   = idx_reg;
        if (cmd.exec)
        begin
            unique case (kind_reg)
                rpa_pkg::KIND_ALLOC:
                begin
                    if (depth_reg == '0)
                    begin
                        r_st = rpa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = stk_rdata;
                        cnt_wdata  = CNT_ONE;
                        depth_next = depth_dec;
                        r_addr     = AW'(stk_rdata) << PAGE_BITS;
                        r_cnt      = CNT_ONE;
                    end
                end
                rpa_pkg::KIND_FREE:
                begin
                    if (!aligned_reg || !valid_reg)
                    begin
                        r_st = rpa_pkg::ST_BADADDR;
                    end
                    else if (cnt_rdata == '0)
                    begin
                        r_st = rpa_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_dec;
                        r_cnt     = cnt_dec;
                        // Last reference gone: the page goes back on the stack unless it is full.
                        if ((cnt_dec == '0) && (depth_reg != DEP_FULL))
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DEP_W'(1);
                        end
                    end
                end
                rpa_pkg::KIND_ADD:
                begin
                    if (!valid_reg)
                    begin
                        r_st = rpa_pkg::ST_BADADDR;
                    end
                    else if (cnt_rdata == CNT_MAX)
                    begin
                        r_st  = rpa_pkg::ST_SATURATED;
                        r_cnt = cnt_rdata;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_inc;
                        r_cnt     = cnt_inc;
                    end
                end
                rpa_pkg::KIND_READ:
                begin
                    if (!valid_reg)
                    begin
                        r_st = rpa_pkg::ST_BADADDR;
                    end
                    else
                    begin
                        r_cnt = cnt_rdata;
                    end
                end
                rpa_pkg::KIND_INIT:
                begin
                    depth_next = '0;
                    idx_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.sweep)
        begin
            // Clear one count; during init also stack pages of the region.
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg;
            cnt_wdata = '0;
            if (cmd.push && idx_in_region)
            begin
                stk_we     = 1'b1;
                stk_wdata  = idx_reg;
                depth_next = depth_reg + DEP_W'(1);
            end
            idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + PG_W'(1);
        end
    end

    // The count field of a word is the low sixteen bits of the count.
    assign r_cnt_w = AW'(r_cnt);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            end_page_reg   <= '0;
            depth_reg      <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rpa_pkg::CFG_FIRST_PAGE:
                        first_page_reg <= cfg_data[rpa_pkg::FIRST_W-1:0];
                    rpa_pkg::CFG_END_PAGE:
                        end_page_reg <= cfg_data[rpa_pkg::END_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            depth_reg <= depth_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg    <= in_kind;
            page_reg    <= in_page[PG_W-1:0];
            valid_reg   <= in_page_ok;
            aligned_reg <= (in_page_addr[PAGE_BITS-1:0] == '0);
        end
        if (cmd.exec)
        begin
            hold_addr_reg <= r_addr;
            hold_cnt_reg  <= r_cnt_w[rpa_pkg::REFCNT_W-1:0];
            hold_st_reg   <= r_st;
        end
        if (cmd.load_out)
        begin
            if (cmd.out_from_hold)
            begin
                out_addr_reg <= hold_addr_reg;
                out_cnt_reg  <= hold_cnt_reg;
                out_st_reg   <= hold_st_reg;
            end
            else
            begin
                out_addr_reg <= r_addr;
                out_cnt_reg  <= r_cnt_w[rpa_pkg::REFCNT_W-1:0];
                out_st_reg   <= r_st;
            end
        end
    end

    assign out_result_addr = out_addr_reg;
    assign out_ref_count   = out_cnt_reg;
    assign out_status      = out_st_reg;

endmodule
